FILE: hdl/cfbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cassette FSK byte framer package
// Item types, configuration register indexes and reset values shared by
// the framer modules.
// ----------------------------------------------------------------------------
package cfbf_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned DUR_W       = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MARK_HALF_PERIOD  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_HALF_PERIOD = 8'd1;

  localparam logic [DUR_W-1:0] MARK_RESET  = 16'd272;
  localparam logic [DUR_W-1:0] SPACE_RESET = 16'd544;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] half_period;
    logic             last_of_byte;
    logic             done_res;
  } out_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] mark_half_period;
    logic [DUR_W-1:0] space_half_period;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic finished;
  } seq_status_t;

endpackage
`default_nettype wire

FILE: hdl/cfbf_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framer configuration registers
// Holds the mark and space half-period durations. Writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module cfbf_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cfbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [cfbf_pkg::DUR_W-1:0]         cfg_data,
  output cfbf_pkg::cfg_t                          cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mark_half_period  <= cfbf_pkg::MARK_RESET;
      cfg.space_half_period <= cfbf_pkg::SPACE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == cfbf_pkg::REG_MARK_HALF_PERIOD) begin
        cfg.mark_half_period <= cfg_data;
      end else if (cfg_index == cfbf_pkg::REG_SPACE_HALF_PERIOD) begin
        cfg.space_half_period <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cfbf_frame_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framer bit and half-period sequencer
// Holds the accepted byte and steps through start, data and stop bits,
// loading one half-period per cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
module cfbf_frame_seq #(
  parameter int unsigned HALVES_PER_BIT = 4,
  parameter int unsigned DATA_BITS      = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfbf_pkg::cfg_t       cfg,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire cfbf_pkg::in_item_t   byte_item,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output cfbf_pkg::out_item_t       res_item,
  output cfbf_pkg::seq_status_t     status
);

  localparam int unsigned BIT_W  = $clog2(DATA_BITS + 3);
  localparam int unsigned HALF_W = (HALVES_PER_BIT > 1) ? $clog2(HALVES_PER_BIT) : 1;
  localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(DATA_BITS + 2);
  localparam logic [BIT_W-1:0]  DATA_LAST = BIT_W'(DATA_BITS);
  localparam logic [HALF_W-1:0] HALF_LAST = HALF_W'(HALVES_PER_BIT - 1);

  logic              busy;
  logic              finished;
  logic              is_end;
  logic [7:0]        shift_byte;
  logic [BIT_W-1:0]  bit_cnt;
  logic [HALF_W-1:0] half_cnt;

  logic adv;
  logic take;
  logic last_half;
  logic last_step;
  logic in_data;
  logic bit_val;

  // Position 0 is the start bit, 1 to DATA_BITS the data bits, then two stops.
  assign in_data   = (bit_cnt != '0) && (bit_cnt <= DATA_LAST);
  assign bit_val   = (bit_cnt == '0) ? 1'b0 :
                     (in_data ? shift_byte[DATA_BITS-1] : 1'b1);
  assign last_half = (half_cnt == HALF_LAST);
  assign last_step = is_end || (last_half && (bit_cnt == LAST_BIT));
  assign adv       = busy && (!res_valid || !res_stall);
  assign byte_stall = busy && !(adv && last_step);
  assign take      = byte_valid && !byte_stall;

  assign status.busy     = busy;
  assign status.finished = finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      finished  <= 1'b0;
      is_end    <= 1'b0;
      res_valid <= 1'b0;
      bit_cnt   <= '0;
      half_cnt  <= '0;
    end else begin
      if (adv) begin
        res_valid             <= 1'b1;
        res_item.half_period  <= is_end ? '0 :
                                 (bit_val ? cfg.mark_half_period : cfg.space_half_period);
        res_item.last_of_byte <= last_step;
        res_item.done_res     <= is_end;
        if (!last_step) begin
          if (last_half) begin
            half_cnt <= '0;
            bit_cnt  <= bit_cnt + 1'b1;
            if (in_data) begin
              shift_byte <= {shift_byte[6:0], 1'b0};
            end
          end else begin
            half_cnt <= half_cnt + 1'b1;
          end
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      if (take) begin
        busy       <= 1'b1;
        is_end     <= finished || byte_item.end_of_data;
        finished   <= finished || byte_item.end_of_data;
        shift_byte <= byte_item.data_byte;
        bit_cnt    <= '0;
        half_cnt   <= '0;
      end else if (adv && last_step) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cassette_fsk_byte_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cassette FSK byte framer
// Frames bytes as start bit, data bits MSB first and two stop bits, and
// emits one square-wave half-period duration per result item.
// ----------------------------------------------------------------------------
// Usage:
// The byte channel (byte_valid, byte_stall, byte_item) takes one data byte or
// an end-of-data marker per item. The result channel (res_valid, res_stall,
// res_item) returns half-period durations, one item per cycle when the
// receiver does not stall. A byte yields (DATA_BITS + 3) * HALVES_PER_BIT
// items, 44 with the default parameters, the last flagged by last_of_byte.
// An end marker, and every item after it, yields one item with duration zero
// and both flags set.
// The sequencer registers the taken item, then loads its first result into
// the result register. A byte occupies the sequencer until its final result
// is loaded; the next byte is taken in the cycle its predecessor's final
// result is loaded, so bytes follow with no gap.
// When the receiver stalls, the result register holds and the sequencer
// waits; the byte channel stalls until the frame completes.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the mark duration and index 1 the space duration.
// Reset (synchronous, active high) restores durations 272 and 544, empties
// the output register and clears the end-of-stream condition.
// ----------------------------------------------------------------------------
module cassette_fsk_byte_framer #(
  parameter int unsigned HALVES_PER_BIT = 4,
  parameter int unsigned DATA_BITS      = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              byte_valid,
  output logic                                   byte_stall,
  input  wire cfbf_pkg::in_item_t                byte_item,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output cfbf_pkg::out_item_t                    res_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cfbf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [cfbf_pkg::DUR_W-1:0]        cfg_data
);

  // Current durations from the register block.
  cfbf_pkg::cfg_t        cfg;
  // Sequencer status, used by the checks below.
  cfbf_pkg::seq_status_t status;

  cfbf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sequencer holds the accepted byte, the bit and half-period counters
  // and the result register.
  cfbf_frame_seq #(
    .HALVES_PER_BIT (HALVES_PER_BIT),
    .DATA_BITS      (DATA_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .status     (status)
  );

`ifndef NO_ASSERTIONS
  // An end result always carries zero duration and the frame-end flag.
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.done_res |-> res_item.half_period == '0 && res_item.last_of_byte)
    else $error("end result with nonzero duration or without frame-end flag");

  // Once the stream has ended it stays ended until reset.
  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    status.finished |=> status.finished)
    else $error("end-of-stream condition cleared without reset");

  // A taken item always starts work in the sequencer.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall |=> status.busy)
    else $error("accepted item did not start the sequencer");

  // An accepted end marker leaves the stream finished.
  a_end_marks: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_item.end_of_data |=> status.finished)
    else $error("end marker did not finish the stream");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/cfbf_frame_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cassette FSK byte framer scoreboard
// Predicts the half-period items of each accepted byte or end marker and
// checks the result items against them in order.
// ----------------------------------------------------------------------------
package cfbf_frame_check_pkg;

  class frame_scoreboard;
    int unsigned                halves_per_bit;
    int unsigned                byte_bits;
    logic [cfbf_pkg::DUR_W-1:0] mark_dur;
    logic [cfbf_pkg::DUR_W-1:0] space_dur;
    bit                         stream_ended;
    cfbf_pkg::out_item_t        pending_halves[$];
    int unsigned                failures;

    function new(int unsigned halves, int unsigned byte_width);
      halves_per_bit = halves;
      byte_bits      = byte_width;
      mark_dur       = cfbf_pkg::MARK_RESET;
      space_dur      = cfbf_pkg::SPACE_RESET;
      stream_ended   = 1'b0;
      failures       = 0;
    endfunction

    // Indexes other than the two durations leave both untouched.
    function void write_duration(logic [cfbf_pkg::CFG_INDEX_W-1:0] index,
                                 logic [cfbf_pkg::DUR_W-1:0] value);
      if (index == cfbf_pkg::REG_MARK_HALF_PERIOD) begin
        mark_dur = value;
      end else if (index == cfbf_pkg::REG_SPACE_HALF_PERIOD) begin
        space_dur = value;
      end
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s", $time, what);
      end
    endfunction

    // Expands one accepted item into the half-period items it should cause.
    // Frame bit 0 is the start bit, then the data bits from the highest used
    // bit down, then two stop bits.
    function void queue_frame(cfbf_pkg::in_item_t item);
      cfbf_pkg::out_item_t half;
      bit                  one;
      int unsigned         frame_bits;

      if (stream_ended || item.end_of_data) begin
        stream_ended = 1'b1;
        half.half_period  = '0;
        half.last_of_byte = 1'b1;
        half.done_res     = 1'b1;
        pending_halves.push_back(half);
        return;
      end
      frame_bits = byte_bits + 3;
      for (int b = 0; b < frame_bits; b++) begin
        if (b == 0) begin
          one = 1'b0;
        end else if (b <= byte_bits) begin
          one = item.data_byte[byte_bits - b];
        end else begin
          one = 1'b1;
        end
        for (int h = 0; h < halves_per_bit; h++) begin
          half.half_period  = one ? mark_dur : space_dur;
          half.last_of_byte = (b == frame_bits - 1) && (h == halves_per_bit - 1);
          half.done_res     = 1'b0;
          pending_halves.push_back(half);
        end
      end
    endfunction

    function void check_half_period(cfbf_pkg::out_item_t got);
      cfbf_pkg::out_item_t want;

      if (pending_halves.size() == 0) begin
        note_failure($sformatf("unexpected item: half_period %0d last_of_byte %b done_res %b",
                               got.half_period, got.last_of_byte, got.done_res));
        return;
      end
      want = pending_halves.pop_front();
      if (got.half_period !== want.half_period || got.last_of_byte !== want.last_of_byte ||
          got.done_res !== want.done_res) begin
        note_failure($sformatf({"half_period %0d (expected %0d), last_of_byte %b (expected %b),",
                                " done_res %b (expected %b)"},
                               got.half_period, want.half_period, got.last_of_byte,
                               want.last_of_byte, got.done_res, want.done_res));
      end
    endfunction

    function void close_out();
      if (pending_halves.size() != 0) begin
        note_failure($sformatf("%0d expected items never arrived", pending_halves.size()));
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/cassette_fsk_byte_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cassette FSK byte framer testbench
// Drives bytes and end markers through the framer under random idling on
// both channels, reprograms the mark and space durations between phases,
// and checks every half-period item against an in-order prediction.
// ----------------------------------------------------------------------------
module cassette_fsk_byte_framer_test;

  localparam int unsigned HALVES        = 4;
  localparam int unsigned DBITS         = 8;
  // Cycles with no accepted item on any channel before the run is declared hung.
  // The long receiver hold is the longest legal quiet stretch, far below this.
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned LONG_HOLD     = 300;
  // Settling time after the last predicted result, covering the output register.
  localparam int unsigned SETTLE        = 8;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned TAIL_BYTES    = 24;

  // Indexes that no register answers to; writes there must be ignored.
  localparam logic [cfbf_pkg::CFG_INDEX_W-1:0] REG_INDEX_PAST_END =
    cfbf_pkg::REG_SPACE_HALF_PERIOD + 8'd1;
  localparam logic [cfbf_pkg::CFG_INDEX_W-1:0] REG_INDEX_TOP      = '1;

  // Bytes chosen for the extremes and for alternating bit patterns.
  localparam logic [7:0] CORNER_BYTES [12] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55,
                                                8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h3C, 8'hC3};

  logic                             clk        = 1'b0;
  logic                             rst        = 1'b1;
  logic                             byte_valid = 1'b0;
  logic                             byte_stall;
  cfbf_pkg::in_item_t               byte_item  = '0;
  logic                             res_valid;
  logic                             res_stall  = 1'b0;
  cfbf_pkg::out_item_t              res_item;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [cfbf_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [cfbf_pkg::DUR_W-1:0]       cfg_data   = '0;

  cfbf_frame_check_pkg::frame_scoreboard sb = new(HALVES, DBITS);

  // Knobs for the sender and receiver. The receiver flags are only changed
  // just after a rising edge so the receiver, which acts on falling edges,
  // never races with the main sequence.
  bit          send_idling   = 1'b1;
  bit          recv_idling   = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_left    = 0;
  int unsigned idle_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cassette_fsk_byte_framer #(
    .HALVES_PER_BIT (HALVES),
    .DATA_BITS      (DBITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Receiver. It stalls in bursts of random length, sometimes keeps quiet
  // for a longer stretch, and on request holds off for a long stretch set by
  // LONG_HOLD so that the framer fills up and has to stall the byte channel.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      res_stall <= 1'b1;
    end else if (quiet_left != 0) begin
      quiet_left--;
      res_stall <= 1'b0;
    end else if (recv_idling && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 15);
      res_stall <= 1'b1;
    end else begin
      if (recv_idling && $urandom_range(0, 31) == 0) begin
        quiet_left = $urandom_range(20, 100);
      end
      res_stall <= 1'b0;
    end
  end

  // Every result item taken by the receiver is checked against the oldest
  // prediction. Inputs only move on falling edges, so values read here are
  // the ones the framer saw at this edge.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      sb.check_half_period(res_item);
    end
  end

  // Watchdog: any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cassette_fsk_byte_framer verification failed");
      $finish;
    end
  end

  function automatic cfbf_pkg::in_item_t data_item(logic [7:0] value);
    cfbf_pkg::in_item_t item;
    item.data_byte   = value;
    item.end_of_data = 1'b0;
    return item;
  endfunction

  // Mostly ordinary durations, with the extremes (zero among them) now and then.
  function automatic logic [cfbf_pkg::DUR_W-1:0] pick_duration();
    unique case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return 16'd1;
      end
      default: begin
        return cfbf_pkg::DUR_W'($urandom_range(1, 65535));
      end
    endcase
  endfunction

  // Offers one item, entered and left at a falling edge. Valid stays high
  // when the next item follows at once, so a fresh item never needs valid
  // lowered and raised in the same step.
  task automatic offer_item(input cfbf_pkg::in_item_t item);
    if (send_idling && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= item;
    do @(posedge clk); while (byte_stall);
    sb.queue_frame(item);
    @(negedge clk);
  endtask

  // Stops offering and waits for every predicted item to come back. Every
  // accepted item causes at least one result, so an empty queue means the
  // framer is idle; a few cycles more cover the output register.
  task automatic wait_frames_sent();
    byte_valid <= 1'b0;
    while (sb.pending_halves.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register write; leaves at a falling edge after valid has dropped.
  task automatic write_reg(input logic [cfbf_pkg::CFG_INDEX_W-1:0] index,
                           input logic [cfbf_pkg::DUR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_duration(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset durations: all-zero, all-one, single
    // bits at each end and alternating patterns.
    foreach (CORNER_BYTES[i]) begin
      offer_item(data_item(CORNER_BYTES[i]));
    end

    // A zero mark duration and the widest space duration, plus writes to
    // indexes that do not exist, which must change nothing.
    wait_frames_sent();
    write_reg(cfbf_pkg::REG_MARK_HALF_PERIOD, '0);
    write_reg(cfbf_pkg::REG_SPACE_HALF_PERIOD, '1);
    write_reg(REG_INDEX_PAST_END, 16'h1234);
    write_reg(REG_INDEX_TOP, '1);
    offer_item(data_item(8'h00));
    offer_item(data_item(8'hFF));
    offer_item(data_item(8'h5A));

    // The mirror case: widest mark, zero space.
    wait_frames_sent();
    write_reg(cfbf_pkg::REG_MARK_HALF_PERIOD, '1);
    write_reg(cfbf_pkg::REG_SPACE_HALF_PERIOD, '0);
    offer_item(data_item(8'h00));
    offer_item(data_item(8'hFF));
    offer_item(data_item(8'hA5));

    // Smallest legal durations on both.
    wait_frames_sent();
    write_reg(cfbf_pkg::REG_MARK_HALF_PERIOD, 16'd1);
    write_reg(cfbf_pkg::REG_SPACE_HALF_PERIOD, 16'd1);
    offer_item(data_item(8'h69));
    offer_item(data_item(8'h96));

    // Random phases, each with fresh durations. The stream must not end
    // here: reset comes only once, and an end marker would turn every later
    // item into an end result.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_frames_sent();
      write_reg(cfbf_pkg::REG_MARK_HALF_PERIOD, pick_duration());
      write_reg(cfbf_pkg::REG_SPACE_HALF_PERIOD, pick_duration());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(cfbf_pkg::CFG_INDEX_W'($urandom_range(REG_INDEX_PAST_END, REG_INDEX_TOP)),
                  cfbf_pkg::DUR_W'($urandom));
      end
      send_idling = ($urandom_range(0, 2) != 0);
      // In the second phase the receiver holds off for a long stretch while
      // the sender keeps offering, so the byte channel backs up.
      if (phase == 1) begin
        @(posedge clk);
        long_hold_req = 1'b1;
        @(negedge clk);
      end
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // Once, the sender pauses mid-phase until the framer has drained.
        if (phase == 3 && k == PHASE_ITEMS / 2) begin
          wait_frames_sent();
        end
        offer_item(data_item(8'($urandom_range(0, 255))));
      end
    end

    // Last part: no idling on either side. A run of random bytes, then the
    // end of the stream, then bytes and repeated markers after it, which
    // must each give the single end result again.
    wait_frames_sent();
    write_reg(cfbf_pkg::REG_MARK_HALF_PERIOD, pick_duration());
    write_reg(cfbf_pkg::REG_SPACE_HALF_PERIOD, pick_duration());
    @(posedge clk);
    recv_idling = 1'b0;
    hold_left   = 0;
    quiet_left  = 0;
    @(negedge clk);
    send_idling = 1'b0;
    repeat (TAIL_BYTES) begin
      offer_item(data_item(8'($urandom_range(0, 255))));
    end
    offer_item('{data_byte: 8'hFF, end_of_data: 1'b1});
    offer_item(data_item(8'h00));
    offer_item('{data_byte: 8'h00, end_of_data: 1'b1});
    repeat (8) begin
      offer_item('{data_byte: 8'($urandom_range(0, 255)), end_of_data: 1'($urandom_range(0, 1))});
    end

    wait_frames_sent();
    sb.close_out();
    if (sb.failures == 0) begin
      $display("cassette_fsk_byte_framer verification clean");
    end else begin
      $display("cassette_fsk_byte_framer verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cfbf_pkg.sv
hdl/cfbf_regs.sv
hdl/cfbf_frame_seq.sv
hdl/cassette_fsk_byte_framer.sv
tb/sv/cfbf_frame_check_pkg.sv
tb/sv/cassette_fsk_byte_framer_test.sv
